// ===== design/avm_pkg.sv =====
`timescale 1ns / 1ps

package avm_pkg;

    // Field widths of the item formats.
    localparam int RAW_W = 16;
    localparam int MG_W  = 12;
    localparam int MAG_W = 12;

    // Scaling: mg = raw * MG_FULL_SCALE / 2^RAW_SCALE_SHIFT, truncated toward zero.
    localparam int MG_FULL_SCALE   = 2000;
    localparam int RAW_SCALE_SHIFT = 15;
    localparam int ABS_W           = RAW_W + 1;       // magnitude of a raw sample
    localparam int SCALE_W         = 11;              // width of MG_FULL_SCALE
    localparam int PROD_W          = ABS_W + SCALE_W; // raw magnitude times scale
    localparam int QUOT_W          = 11;              // scaled magnitude, at most 2000

    // Squares of milli-g values stay below 2^22, their sum below 2^24.
    localparam int SQ_W  = 22;
    localparam int SUM_W = 24;

    // Square root: one result bit per pipeline stage.
    localparam int ISQ_STEPS = SUM_W / 2;

    // Pipeline layout of the top level.
    localparam int LANE_STAGES = 2;
    localparam int SUM_STAGES  = 1;
    localparam int PIPE_STAGES = LANE_STAGES + SUM_STAGES + ISQ_STEPS;
    localparam int ISQ_FIRST   = LANE_STAGES + SUM_STAGES;

    // Largest possible magnitude: floor(sqrt(3 * 2000^2)).
    localparam int MAG_MAX = 3464;
    localparam int MG_MIN  = -2000;
    localparam int MG_MAX  = 1999;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } in_t;

    typedef struct packed {
        logic signed [MG_W-1:0] x_mg;
        logic signed [MG_W-1:0] y_mg;
        logic signed [MG_W-1:0] z_mg;
        logic [MAG_W-1:0]       vec_mag;
    } out_t;

    typedef struct packed {
        logic signed [MG_W-1:0] x_mg;
        logic signed [MG_W-1:0] y_mg;
        logic signed [MG_W-1:0] z_mg;
    } mg_t;

endpackage

// ===== design/accel_vector_magnitude.sv =====
`timescale 1ns / 1ps

// Converts one raw three-axis accelerometer sample (+/-2 g, 16-bit two's
// complement per axis) into milli-g values and the floor square root of the
// sum of their squares. The block is a 15-stage pipeline and accepts one item
// every clock cycle unless a stalled output has filled it up. Three identical
// lanes each scale one axis (one stage) and square it (one stage), a merging
// stage adds the three squares, and twelve square root stages each settle
// one bit of the magnitude. The last stage is the output register. Every
// stage holds its own valid bit and loads whenever it is empty or its content
// moves on, so bubbles are squeezed out while the output is stalled, and
// in_ready drops only when all 15 stages hold items. The block keeps no state
// between items and needs no setup after reset.
module accel_vector_magnitude (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  avm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output avm_pkg::out_t out_data
);
    import avm_pkg::*;

    // Stage map: 0 scale, 1 square, 2 sum, 3 .. PIPE_STAGES-1 square root.
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES:0]   advance;

    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;
    logic [SQ_W-1:0]  sq_z;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    logic [MAG_W-1:0] root;

    mg_t mg_lane;
    mg_t mg_pipe_reg [1:PIPE_STAGES-1];

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        advance[PIPE_STAGES] = out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (advance[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (advance[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    avm_lane u_lane_x (
        .clk       (clk),
        .scale_en  (advance[0]),
        .square_en (advance[1]),
        .raw       (in_data.raw_x),
        .mg        (mg_lane.x_mg),
        .sq        (sq_x)
    );

    avm_lane u_lane_y (
        .clk       (clk),
        .scale_en  (advance[0]),
        .square_en (advance[1]),
        .raw       (in_data.raw_y),
        .mg        (mg_lane.y_mg),
        .sq        (sq_y)
    );

    avm_lane u_lane_z (
        .clk       (clk),
        .scale_en  (advance[0]),
        .square_en (advance[1]),
        .raw       (in_data.raw_z),
        .mg        (mg_lane.z_mg),
        .sq        (sq_z)
    );

    // Merging stage: the three squares fit well inside the sum width.
    assign sum_next = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

    always_ff @(posedge clk)
    begin
        if (advance[LANE_STAGES])
        begin
            sum_reg <= sum_next;
        end
    end

    avm_isqrt u_isqrt (
        .clk      (clk),
        .stage_en (advance[PIPE_STAGES-1:ISQ_FIRST]),
        .sum      (sum_reg),
        .root     (root)
    );

    // The milli-g values travel alongside the square root stages.
    always_ff @(posedge clk)
    begin
        if (advance[1])
        begin
            mg_pipe_reg[1] <= mg_lane;
        end
        for (int k = 2; k < PIPE_STAGES; k++)
        begin
            if (advance[k])
            begin
                mg_pipe_reg[k] <= mg_pipe_reg[k-1];
            end
        end
    end

    assign in_ready         = advance[0];
    assign out_valid        = valid_reg[PIPE_STAGES-1];
    assign out_data.x_mg    = mg_pipe_reg[PIPE_STAGES-1].x_mg;
    assign out_data.y_mg    = mg_pipe_reg[PIPE_STAGES-1].y_mg;
    assign out_data.z_mg    = mg_pipe_reg[PIPE_STAGES-1].z_mg;
    assign out_data.vec_mag = root;

endmodule

// ===== design/avm_lane.sv =====
`timescale 1ns / 1ps

// One axis: scale a raw sample to milli-g, then square it.
module avm_lane (
    input  logic                             clk,
    input  logic                             scale_en,
    input  logic                             square_en,
    input  logic signed [avm_pkg::RAW_W-1:0] raw,
    output logic signed [avm_pkg::MG_W-1:0]  mg,
    output logic [avm_pkg::SQ_W-1:0]         sq
);
    import avm_pkg::*;

    logic                     neg;
    logic [ABS_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [QUOT_W-1:0]        quot;
    logic signed [MG_W-1:0]   mg_next;
    logic signed [MG_W-1:0]   mg_reg;
    logic signed [2*MG_W-1:0] sq_full;
    logic [SQ_W-1:0]          sq_next;
    logic [SQ_W-1:0]          sq_reg;

    always_comb
    begin
        neg  = raw[RAW_W-1];
        mag  = neg ? (ABS_W'(0) - ABS_W'(raw)) : ABS_W'(raw);
        prod = PROD_W'(mag) * PROD_W'(MG_FULL_SCALE);
        quot = prod[RAW_SCALE_SHIFT +: QUOT_W];
        mg_next = neg ? -$signed(MG_W'(quot)) : $signed(MG_W'(quot));
    end

    always_comb
    begin
        sq_full = mg_reg * mg_reg;
        sq_next = sq_full[SQ_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (scale_en)
        begin
            mg_reg <= mg_next;
        end
        if (square_en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign mg = mg_reg;
    assign sq = sq_reg;

endmodule

// ===== design/avm_isqrt.sv =====
`timescale 1ns / 1ps

// Pipelined floor square root, one result bit settled in each stage.
module avm_isqrt (
    input  logic                          clk,
    input  logic [avm_pkg::ISQ_STEPS-1:0] stage_en,
    input  logic [avm_pkg::SUM_W-1:0]     sum,
    output logic [avm_pkg::MAG_W-1:0]     root
);
    import avm_pkg::*;

    logic [SUM_W-1:0] rem_reg  [ISQ_STEPS];
    logic [SUM_W-1:0] root_reg [ISQ_STEPS];

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_step
        localparam logic [SUM_W:0] PROBE = (SUM_W+1)'(1) << (2 * (ISQ_STEPS - 1 - k));

        logic [SUM_W-1:0] rem_prev;
        logic [SUM_W-1:0] root_prev;
        logic [SUM_W:0]   trial;
        logic             take;
        logic [SUM_W-1:0] rem_next;
        logic [SUM_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = sum;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, root_prev} + PROBE;
            take  = {1'b0, rem_prev} >= trial;
            if (take)
            begin
                rem_next  = rem_prev - trial[SUM_W-1:0];
                root_next = (root_prev >> 1) + PROBE[SUM_W-1:0];
            end
            else
            begin
                rem_next  = rem_prev;
                root_next = root_prev >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[ISQ_STEPS-1][MAG_W-1:0];

endmodule

// ===== design/avm_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the vector magnitude block.
module avm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input avm_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input avm_pkg::out_t out_data
);
    import avm_pkg::*;

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // Input back-pressure only comes from a full pipeline behind a stalled output.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused while the pipeline has room");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_data.vec_mag) <= MAG_MAX)
        else $error("magnitude out of range");

    a_mg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_data.x_mg) >= MG_MIN && int'(out_data.x_mg) <= MG_MAX
                   && int'(out_data.y_mg) >= MG_MIN && int'(out_data.y_mg) <= MG_MAX
                   && int'(out_data.z_mg) >= MG_MIN && int'(out_data.z_mg) <= MG_MAX)
        else $error("milli-g value out of range");

endmodule

bind accel_vector_magnitude avm_checker u_avm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/avm_result_check.sv =====
`timescale 1ns / 1ps

// Watches both channels of the vector magnitude block. Every item accepted at
// the input is turned into the expected reading and queued. Every item accepted
// at the output is compared field by field with the oldest queued reading.
module avm_result_check (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  avm_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  avm_pkg::out_t out_data,
    output int            failures,
    output int            outstanding
);

    import avm_pkg::*;

    out_t expected_readings[$];

    // Scales one raw sample to milli-g. The quotient is truncated toward zero.
    function automatic logic [MG_W-1:0] scale_raw(input logic [RAW_W-1:0] raw);
        logic [RAW_W:0] abs_raw;
        logic [31:0]    quot;
        abs_raw = raw[RAW_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        quot = ({15'd0, abs_raw} * 32'(MG_FULL_SCALE)) >> RAW_SCALE_SHIFT;
        return raw[RAW_W-1] ? -quot[MG_W-1:0] : quot[MG_W-1:0];
    endfunction

    // Floor square root, one result bit per step.
    function automatic logic [MAG_W-1:0] floor_root(input logic [63:0] radicand);
        logic [63:0] probe;
        logic [63:0] root;
        logic [63:0] rest;
        probe = 64'd1 << 62;
        root  = '0;
        rest  = radicand;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[MAG_W-1:0];
    endfunction

    function automatic out_t predict_reading(input in_t sample);
        out_t   reading;
        longint xs;
        longint ys;
        longint zs;
        reading.x_mg = scale_raw(sample.raw_x);
        reading.y_mg = scale_raw(sample.raw_y);
        reading.z_mg = scale_raw(sample.raw_z);
        xs = longint'(reading.x_mg);
        ys = longint'(reading.y_mg);
        zs = longint'(reading.z_mg);
        reading.vec_mag = floor_root(64'(xs * xs + ys * ys + zs * zs));
        return reading;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        failures++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            expected_readings.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_readings.push_back(predict_reading(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_error($sformatf("unexpected result x=%0d y=%0d z=%0d mag=%0d",
                        out_data.x_mg, out_data.y_mg, out_data.z_mg,
                        out_data.vec_mag));
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compare_field("x_mg", int'(out_data.x_mg), int'(want.x_mg));
                    compare_field("y_mg", int'(out_data.y_mg), int'(want.y_mg));
                    compare_field("z_mg", int'(out_data.z_mg), int'(want.z_mg));
                    compare_field("vec_mag", int'(out_data.vec_mag),
                        int'(want.vec_mag));
                end
            end
        end
        outstanding = expected_readings.size();
    end

endmodule

// ===== tb/accel_vector_magnitude_test.sv =====
`timescale 1ns / 1ps

// Top of the testbench for the vector magnitude block. It drives raw samples
// into the block, drives the ready of the result channel, and gives the final
// verdict. All prediction and comparison is done by the result checker, which
// sits beside the block and only watches its ports.
module accel_vector_magnitude_test;

    import avm_pkg::*;

    // The watchdog ends the run after this many cycles in which no item moves
    // on either channel. The longest legal quiet stretch is the long hold-off
    // of the receiver, so this leaves a wide margin.
    localparam int QUIET_LIMIT   = 2000;
    // The receiver holds off this long once, which is far more than the block
    // needs to fill all of its pipeline stages.
    localparam int HOLD_CYCLES   = 300;
    // Cycles to wait after the last result, well beyond the pipeline depth.
    localparam int DRAIN_CYCLES  = 40;
    localparam int ITEMS_PER_PHASE = 267;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    int   failures;
    int   outstanding;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic pressure_go;
    int   quiet_cycles;

    accel_vector_magnitude dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    avm_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offers one sample to the block. Before the offer the sender may idle
    // for a few cycles. Once valid is raised it stays high with the same data
    // until the handshake completes. The ready is looked at on the falling
    // edge, when it has settled, so the task returns right at the rising edge
    // that accepts the item.
    task automatic send_sample(input in_t sample);
        logic ready_seen;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= sample;
        do begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end while (!ready_seen);
    endtask

    // One random raw sample. Most are uniform over the whole 16-bit range;
    // the rest sit near zero, where truncation toward zero matters most, or
    // near the two extremes of the range.
    function automatic logic [RAW_W-1:0] random_raw();
        logic [RAW_W-1:0] raw;
        case ($urandom_range(0, 9))
            0, 1: raw = RAW_W'($urandom_range(0, 127)) - 16'd64;
            2, 3: begin
                if ($urandom_range(0, 1) == 1)
                    raw = 16'h7FFF - RAW_W'($urandom_range(0, 31));
                else
                    raw = 16'h8000 + RAW_W'($urandom_range(0, 31));
            end
            default: raw = RAW_W'($urandom_range(0, 65535));
        endcase
        return raw;
    endfunction

    function automatic in_t random_sample();
        in_t sample;
        sample.raw_x = random_raw();
        sample.raw_y = random_raw();
        sample.raw_z = random_raw();
        return sample;
    endfunction

    // Receiver. It stalls at random according to the current idle rate. When
    // the stimulus asks for pressure it holds ready low for a long stretch,
    // counted here, while the sender keeps offering items, so the pipeline
    // fills up and the block has to drop its input ready.
    initial begin
        int  hold_left;
        bit  pressure_done;
        out_ready     = 1'b0;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_go && !pressure_done) begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: counts cycles in which no item is accepted on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("accel_vector_magnitude verification failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        pressure_go   = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 59;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples. Zero, the full-scale extremes on each axis, the
        // largest possible magnitude, small values where truncation toward
        // zero differs from flooring, exact scale points, and a vector whose
        // sum of squares is a perfect square.
        send_sample(in_t'{16'sd0, 16'sd0, 16'sd0});
        send_sample(in_t'{16'sh7FFF, 16'sd0, 16'sd0});
        send_sample(in_t'{16'sd0, 16'sh8000, 16'sd0});
        send_sample(in_t'{16'sd0, 16'sd0, 16'sh7FFF});
        send_sample(in_t'{16'sh8000, 16'sh8000, 16'sh8000});
        send_sample(in_t'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_sample(in_t'{16'sh7FFF, 16'sh8000, 16'sh7FFF});
        send_sample(in_t'{16'sh8000, 16'sh7FFF, 16'sh8000});
        send_sample(in_t'{16'sd1, -16'sd1, 16'sd16});
        send_sample(in_t'{-16'sd16, 16'sd17, -16'sd17});
        send_sample(in_t'{16'sd16384, -16'sd16384, 16'sd0});
        send_sample(in_t'{16'sd9831, 16'sd13108, 16'sd0});
        send_sample(in_t'{-16'sd9831, 16'sd0, -16'sd13108});
        send_sample(in_t'{16'sh8001, 16'sh7FFE, 16'sh5555});
        send_sample(in_t'{16'shAAAA, 16'sh5555, 16'shAAAA});
        send_sample(in_t'{16'shFFFF, 16'shFFFF, 16'shFFFF});

        // Random samples in three phases: sender idles more lightly than the
        // receiver, then the reverse, then neither idles. The long receiver
        // hold-off is started at the head of the last phase, where the sender
        // offers an item every cycle and the block fills up fastest.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    pressure_go <= 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_sample(random_sample());
        end
        in_valid <= 1'b0;

        // Wait for every expected result, then a little longer in case the
        // block produces something it should not.
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("accel_vector_magnitude verification clean");
        else
            $display("accel_vector_magnitude verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/avm_pkg.sv
design/avm_lane.sv
design/avm_isqrt.sv
design/accel_vector_magnitude.sv
design/avm_checker.sv
tb/avm_result_check.sv
tb/accel_vector_magnitude_test.sv
